// ===== design/deadline_sorted_task_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Deadline sorted task queue: assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TASK_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_SORTED_TASK_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define DSTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dstq_pkg.sv =====
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared constants and handshake types of the deadline sorted task queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int OWNERS_DEF = 16;
  localparam int KINDS_DEF  = 64;
  localparam int DL_W       = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PURGE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKLIST_KIND  = 1'd1;

  typedef struct packed {
    logic start;
    logic take;
  } ctl_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctl_stat_t;

endpackage

// ===== design/dstq_mem.sv =====
// ----------------------------------------------------------------------------
// dstq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dstq_mem #(
  parameter int DEPTH = dstq_pkg::DEPTH_DEF,
  parameter int EW = 42,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dstq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dstq_ctrl
// Operation sequencer: streams entries out of the store one per cycle and
// writes them back shifted or compacted; keeps the entry count.
// ----------------------------------------------------------------------------
module dstq_ctrl #(
  parameter int DEPTH = dstq_pkg::DEPTH_DEF,
  parameter int KW = 6,
  parameter int OW = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int EW = dstq_pkg::DL_W + KW + OW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dstq_pkg::ctl_cmd_t       cmd,
  output dstq_pkg::ctl_stat_t      stat,
  input  logic [1:0]               opcode,
  input  logic [dstq_pkg::DL_W-1:0] now_ms,
  input  logic [dstq_pkg::DL_W-1:0] delay_ms,
  input  logic [KW-1:0]            task_kind,
  input  logic [OW-1:0]            owner,
  input  logic                     purge_disconnect,
  input  logic                     purge_checklist,
  input  logic [KW-1:0]            disconnect_kind,
  input  logic [KW-1:0]            checklist_kind,
  output logic                     head_valid,
  output logic [KW-1:0]            head_kind,
  output logic [OW-1:0]            head_owner,
  output logic [dstq_pkg::DL_W-1:0] head_deadline,
  output logic [CW-1:0]            entry_count,
  output logic [1:0]               status,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [EW-1:0]            mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [EW-1:0]            mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRNEW = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t st, st_next;
  logic [CW-1:0] cnt, cnt_next;
  logic more, more_next;
  logic pend, pend_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic [AW-1:0] scan_idx, scan_idx_next;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [CW-1:0] wptr, wptr_next;
  logic seen, seen_next;
  logic [1:0] opr, opr_next;
  logic [dstq_pkg::DL_W-1:0] dl, dl_next;
  logic [KW-1:0] kindr, kindr_next;
  logic [OW-1:0] ownr, ownr_next;
  logic pdisc, pdisc_next;
  logic pchk, pchk_next;
  logic hv, hv_next;
  logic [KW-1:0] hk, hk_next;
  logic [OW-1:0] ho, ho_next;
  logic [dstq_pkg::DL_W-1:0] hd, hd_next;
  logic [1:0] sts, sts_next;

  logic [dstq_pkg::DL_W-1:0] rd_dl;
  logic [KW-1:0] rd_kind;
  logic [OW-1:0] rd_owner;
  logic [EW-1:0] new_ent;
  logic own_hit, drop;
  logic [AW:0] waddr_ext;

  assign rd_dl    = mem_rdata[EW-1 -: dstq_pkg::DL_W];
  assign rd_kind  = mem_rdata[OW +: KW];
  assign rd_owner = mem_rdata[OW-1:0];
  assign new_ent  = {dl, kindr, ownr};
  assign own_hit  = (rd_owner == ownr);
  assign drop     = own_hit && seen && ((rd_kind != disconnect_kind) || pdisc)
                    && ((rd_kind != checklist_kind) || pchk);
  assign waddr_ext = (AW+1)'(mem_waddr);

  always_comb begin
    st_next       = st;
    cnt_next      = cnt;
    more_next     = more;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    scan_idx_next = scan_idx;
    last_idx_next = last_idx;
    wptr_next     = wptr;
    seen_next     = seen;
    opr_next      = opr;
    dl_next       = dl;
    kindr_next    = kindr;
    ownr_next     = ownr;
    pdisc_next    = pdisc;
    pchk_next     = pchk;
    hv_next       = hv;
    hk_next       = hk;
    ho_next       = ho;
    hd_next       = hd;
    sts_next      = sts;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = scan_idx;

    unique case (st)
      S_IDLE: begin
        if (cmd.start) begin
          opr_next      = opcode;
          dl_next       = now_ms + delay_ms;
          kindr_next    = task_kind;
          ownr_next     = owner;
          pdisc_next    = purge_disconnect;
          pchk_next     = purge_checklist;
          hv_next       = 1'b0;
          hk_next       = '0;
          ho_next       = '0;
          hd_next       = '0;
          sts_next      = dstq_pkg::ST_OK;
          seen_next     = 1'b0;
          wptr_next     = '0;
          pend_next     = 1'b0;
          last_idx_next = AW'(cnt - CW'(1));
          unique case (opcode)
            dstq_pkg::OP_INSERT: begin
              if (cnt >= CW'(DEPTH)) begin
                sts_next = dstq_pkg::ST_FULL;
                st_next  = S_OUT;
              end else if (cnt == '0) begin
                st_next = S_WRNEW;
              end else begin
                scan_idx_next = AW'(cnt - CW'(1));
                more_next     = 1'b1;
                st_next       = S_SCAN;
              end
            end
            dstq_pkg::OP_POP: begin
              if (cnt == '0) begin
                sts_next = dstq_pkg::ST_EMPTY;
                st_next  = S_OUT;
              end else begin
                scan_idx_next = '0;
                more_next     = 1'b1;
                st_next       = S_SCAN;
              end
            end
            dstq_pkg::OP_PURGE: begin
              if (cnt == '0) begin
                st_next = S_OUT;
              end else begin
                scan_idx_next = '0;
                more_next     = 1'b1;
                st_next       = S_SCAN;
              end
            end
            default: begin
              st_next = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (more) begin
          mem_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx;
          if (opr == dstq_pkg::OP_INSERT) begin
            if (scan_idx == '0) begin
              more_next = 1'b0;
            end else begin
              scan_idx_next = scan_idx - AW'(1);
            end
          end else if (scan_idx == last_idx) begin
            more_next = 1'b0;
          end else begin
            scan_idx_next = scan_idx + AW'(1);
          end
        end else begin
          pend_next = 1'b0;
        end

        if (pend) begin
          case (opr)
            dstq_pkg::OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx + AW'(1);
              if (rd_dl > dl) begin
                if (pend_idx == '0) begin
                  st_next = S_WRNEW;
                end
              end else begin
                mem_wdata = new_ent;
                cnt_next  = cnt + CW'(1);
                st_next   = S_OUT;
              end
            end
            dstq_pkg::OP_POP: begin
              if (pend_idx == '0) begin
                hv_next = 1'b1;
                hk_next = rd_kind;
                ho_next = rd_owner;
                hd_next = rd_dl;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pend_idx - AW'(1);
              end
              if (pend_idx == last_idx) begin
                cnt_next = cnt - CW'(1);
                st_next  = S_OUT;
              end
            end
            default: begin
              if (!drop) begin
                mem_we    = 1'b1;
                mem_waddr = wptr[AW-1:0];
                wptr_next = wptr + CW'(1);
              end
              if (own_hit) begin
                seen_next = 1'b1;
              end
              if (pend_idx == last_idx) begin
                cnt_next = drop ? wptr : wptr + CW'(1);
                st_next  = S_OUT;
              end
            end
          endcase
        end

        if (st_next != S_SCAN) begin
          pend_next = 1'b0;
          more_next = 1'b0;
        end
      end

      S_WRNEW: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_ent;
        cnt_next  = cnt + CW'(1);
        st_next   = S_OUT;
      end

      S_OUT: begin
        if (cmd.take) begin
          st_next = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      cnt  <= '0;
      more <= 1'b0;
      pend <= 1'b0;
    end else begin
      st   <= st_next;
      cnt  <= cnt_next;
      more <= more_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    scan_idx <= scan_idx_next;
    last_idx <= last_idx_next;
    wptr     <= wptr_next;
    seen     <= seen_next;
    opr      <= opr_next;
    dl       <= dl_next;
    kindr    <= kindr_next;
    ownr     <= ownr_next;
    pdisc    <= pdisc_next;
    pchk     <= pchk_next;
    hv       <= hv_next;
    hk       <= hk_next;
    ho       <= ho_next;
    hd       <= hd_next;
    sts      <= sts_next;
  end

  assign stat.idle     = (st == S_IDLE);
  assign stat.done     = (st == S_OUT);
  assign head_valid    = hv;
  assign head_kind     = hk;
  assign head_owner    = ho;
  assign head_deadline = hd;
  assign entry_count   = cnt;
  assign status        = sts;

`include "deadline_sorted_task_queue_core_assert.svh"

  `DSTQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= CW'(DEPTH), "entry count above depth")
  `DSTQ_ASSERT_IMP(a_wr_in_range, mem_we, waddr_ext < (AW+1)'(DEPTH), "write past store")
  `DSTQ_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read/write clash")
  `DSTQ_ASSERT_IMP(a_pend_scan, pend, st == S_SCAN, "read in flight outside scan")
  `DSTQ_ASSERT_NXT(a_start_leaves, cmd.start && st == S_IDLE, st != S_IDLE, "start ignored")

endmodule

// ===== design/deadline_sorted_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// deadline_sorted_task_queue_core
// Task queue kept in deadline order in one synchronous store; insert, pop
// head and per-owner purge, with config registers and a result register.
//
//   channel | valid      | stall      | word
//   --------+------------+------------+---------------------------------------
//   req     | req_valid  | req_stall  | opcode, now_ms, delay_ms, task_kind,
//           |            |            | owner, purge_disconnect, purge_checklist
//   rsp     | rsp_valid  | rsp_stall  | head_valid, head_kind, head_owner,
//           |            |            | head_deadline, entry_count, status
//   cfg     | cfg_we     | -          | cfg_index, cfg_data
//
// Insert shifts later-deadline entries up one place from the tail and writes
// the new one; pop and purge read every entry; no-op, flagged cases and purge
// of an empty queue skip the store. One store entry per cycle through the
// single read and write port. The result waits in the sequencer while rsp
// holds an earlier one. A new word is taken once the sequencer is idle, even
// while rsp is stalled. Reset clears the count; the store needs no clearing.
// ----------------------------------------------------------------------------
module deadline_sorted_task_queue_core #(
  parameter int DEPTH = dstq_pkg::DEPTH_DEF,
  parameter int OWNERS = dstq_pkg::OWNERS_DEF,
  parameter int KINDS = dstq_pkg::KINDS_DEF,
  localparam int KW = $clog2(KINDS),
  localparam int OW = $clog2(OWNERS),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dstq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [KW-1:0]                 cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    opcode,
  input  logic [dstq_pkg::DL_W-1:0]      now_ms,
  input  logic [dstq_pkg::DL_W-1:0]      delay_ms,
  input  logic [KW-1:0]                 task_kind,
  input  logic [OW-1:0]                 owner,
  input  logic                          purge_disconnect,
  input  logic                          purge_checklist,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          head_valid,
  output logic [KW-1:0]                 head_kind,
  output logic [OW-1:0]                 head_owner,
  output logic [dstq_pkg::DL_W-1:0]      head_deadline,
  output logic [CW-1:0]                 entry_count,
  output logic [1:0]                    status
);

  localparam int AW = $clog2(DEPTH);
  localparam int EW = dstq_pkg::DL_W + KW + OW;

  dstq_pkg::ctl_cmd_t  cmd;
  dstq_pkg::ctl_stat_t stat;

  logic [KW-1:0] disc_kind;
  logic [KW-1:0] chk_kind;

  logic                     r_hv;
  logic [KW-1:0]            r_hk;
  logic [OW-1:0]            r_ho;
  logic [dstq_pkg::DL_W-1:0] r_hd;
  logic [CW-1:0]            r_cnt;
  logic [1:0]               r_sts;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  assign req_stall = !stat.idle;
  assign cmd.start = req_valid && stat.idle;
  assign cmd.take  = stat.done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_kind <= '0;
      chk_kind  <= KW'(1);
    end else if (cfg_we) begin
      if (cfg_index == dstq_pkg::REG_DISCONNECT_KIND) begin
        disc_kind <= cfg_data;
      end else if (cfg_index == dstq_pkg::REG_CHECKLIST_KIND) begin
        chk_kind <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      head_valid    <= r_hv;
      head_kind     <= r_hk;
      head_owner    <= r_ho;
      head_deadline <= r_hd;
      entry_count   <= r_cnt;
      status        <= r_sts;
    end
  end

  dstq_ctrl #(
    .DEPTH(DEPTH),
    .KW(KW),
    .OW(OW)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .opcode           (opcode),
    .now_ms           (now_ms),
    .delay_ms         (delay_ms),
    .task_kind        (task_kind),
    .owner            (owner),
    .purge_disconnect (purge_disconnect),
    .purge_checklist  (purge_checklist),
    .disconnect_kind  (disc_kind),
    .checklist_kind   (chk_kind),
    .head_valid       (r_hv),
    .head_kind        (r_hk),
    .head_owner       (r_ho),
    .head_deadline    (r_hd),
    .entry_count      (r_cnt),
    .status           (r_sts),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  dstq_mem #(
    .DEPTH(DEPTH),
    .EW(EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
